// ===== rtl/delay_gradient_aimd_rate_estimator_defines.svh =====
// Assertion macros used by the checker of the rate estimator.
// Each macro expects signals named clk and rst in the enclosing scope.
`ifndef DELAY_GRADIENT_AIMD_RATE_ESTIMATOR_DEFINES_SVH
`define DELAY_GRADIENT_AIMD_RATE_ESTIMATOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DGAIMD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rate estimator check failed");

// Consequent must hold in the cycle after the antecedent.
`define DGAIMD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rate estimator check failed");

`endif

// ===== rtl/dgaimd_pkg.sv =====
package dgaimd_pkg;

  // Field widths.
  localparam int SG_W       = 28;
  localparam int RATE_W     = 24;
  localparam int TIME_W     = 48;
  localparam int SND_W      = 32;
  localparam int THR_W      = 18;
  localparam int HOLD_W     = 16;
  localparam int LIM_W      = 24;
  localparam int STATUS_W   = 3;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 24;

  // EMA weights in units of 1/65536 and the decrease factor.
  localparam logic [16:0] W_KEEP     = 17'd58982;
  localparam logic [16:0] W_NEW      = 17'd6554;
  localparam logic [16:0] ROUND_HALF = 17'd32768;
  localparam logic [15:0] DEC_FACTOR = 16'd55705;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_FIRST   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_OUTLIER = 3'd1;
  localparam logic [STATUS_W-1:0] ST_KEEP    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DEC     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_INC     = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_OVER_THR  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UNDER_THR = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEC_HOLD  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INC_HOLD  = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_RATE  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RATE  = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INC_STEP  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT     = 4'd7;

  typedef struct packed {
    logic [THR_W-1:0]  over_thr;
    logic [THR_W-1:0]  under_thr;
    logic [HOLD_W-1:0] dec_hold;
    logic [HOLD_W-1:0] inc_hold;
    logic [RATE_W-1:0] min_rate;
    logic [RATE_W-1:0] max_rate;
    logic [RATE_W-1:0] inc_step;
    logic [LIM_W-1:0]  limit;
  } cfg_t;

  typedef struct packed {
    logic                     have_prev;
    logic [TIME_W-1:0]        prev_arrival;
    logic [SND_W-1:0]         prev_sender;
    logic signed [SG_W-1:0]   sgrad;
    logic [RATE_W-1:0]        rate;
    logic [TIME_W-1:0]        last_change;
  } state_t;

  typedef struct packed {
    logic [RATE_W-1:0]   rate;
    logic                send;
    logic [STATUS_W-1:0] status;
  } result_t;

  localparam cfg_t CFG_RESET = '{
    over_thr:  18'd4000,
    under_thr: 18'd1000,
    dec_hold:  16'd300,
    inc_hold:  16'd1500,
    min_rate:  24'd800000,
    max_rate:  24'd8000000,
    inc_step:  24'd250000,
    limit:     24'd200000
  };

  localparam state_t STATE_RESET = '{
    have_prev:    1'b0,
    prev_arrival: '0,
    prev_sender:  '0,
    sgrad:        '0,
    rate:         24'd3000000,
    last_change:  '0
  };

endpackage

// ===== rtl/dgaimd_cfg.sv =====
module dgaimd_cfg
  import dgaimd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  // Register file; unknown indexes are ignored and data is truncated.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_OVER_THR:  cfg.over_thr  <= cfg_data[THR_W-1:0];
        REG_UNDER_THR: cfg.under_thr <= cfg_data[THR_W-1:0];
        REG_DEC_HOLD:  cfg.dec_hold  <= cfg_data[HOLD_W-1:0];
        REG_INC_HOLD:  cfg.inc_hold  <= cfg_data[HOLD_W-1:0];
        REG_MIN_RATE:  cfg.min_rate  <= cfg_data[RATE_W-1:0];
        REG_MAX_RATE:  cfg.max_rate  <= cfg_data[RATE_W-1:0];
        REG_INC_STEP:  cfg.inc_step  <= cfg_data[RATE_W-1:0];
        REG_LIMIT:     cfg.limit     <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/dgaimd_update.sv =====
module dgaimd_update
  import dgaimd_pkg::*;
#(
  parameter int SMOOTH_FRAC_BITS = 8
) (
  input  cfg_t              cfg,
  input  state_t            st,
  input  logic [SND_W-1:0]  sender,
  input  logic [TIME_W-1:0] arrival,
  input  logic [TIME_W-1:0] now,
  output state_t            st_next,
  output result_t           res
);

  // Gradient is the difference of two deltas below 2^24.
  localparam int GRAD_W = LIM_W + 1;
  localparam int G_W    = GRAD_W + SMOOTH_FRAC_BITS;
  localparam int ACC_W  = ((G_W + 18) > 47) ? (G_W + 18) : 47;
  localparam int SH_W   = ACC_W - 16;

  logic                     arr_ok;
  logic [TIME_W-1:0]        d_arr;
  logic [SND_W-1:0]         d_snd;
  logic                     outlier;
  logic signed [GRAD_W-1:0] grad;
  logic signed [ACC_W-1:0]  sg_x;
  logic signed [ACC_W-1:0]  g_x;
  logic signed [ACC_W-1:0]  keep_term;
  logic signed [ACC_W-1:0]  new_term;
  logic signed [ACC_W-1:0]  acc;
  logic [SH_W-1:0]          shifted;
  logic                     fits;
  logic signed [SG_W-1:0]   s_new;
  logic signed [ACC_W-1:0]  s_x;
  logic signed [ACC_W-1:0]  over_x;
  logic signed [ACC_W-1:0]  under_x;
  logic                     now_ge;
  logic [TIME_W-1:0]        since;
  logic                     dec_ok;
  logic                     inc_ok;
  logic [RATE_W+15:0]       prod;
  logic [RATE_W-1:0]        cut;
  logic [RATE_W:0]          up;

  // Deltas against the previous frame and the outlier test.
  always_comb begin
    arr_ok  = arrival > st.prev_arrival;
    d_arr   = arrival - st.prev_arrival;
    d_snd   = sender - st.prev_sender;
    outlier = !arr_ok || (d_arr > TIME_W'(cfg.limit)) || (d_snd == '0) ||
              (d_snd > SND_W'(cfg.limit));
    grad    = $signed({1'b0, d_arr[LIM_W-1:0]}) - $signed({1'b0, d_snd[LIM_W-1:0]});
  end

  // EMA with round to nearest, then saturation to the state width.
  always_comb begin
    sg_x      = ACC_W'(st.sgrad);
    g_x       = ACC_W'(grad) <<< SMOOTH_FRAC_BITS;
    keep_term = sg_x * $signed(ACC_W'(W_KEEP));
    new_term  = g_x * $signed(ACC_W'(W_NEW));
    acc       = keep_term + new_term + $signed(ACC_W'(ROUND_HALF));
    shifted   = acc[ACC_W-1:16];
    fits      = (shifted[SH_W-1:SG_W-1] == '0) || (shifted[SH_W-1:SG_W-1] == '1);
    if (fits) begin
      s_new = shifted[SG_W-1:0];
    end else if (shifted[SH_W-1]) begin
      s_new = {1'b1, {(SG_W-1){1'b0}}};
    end else begin
      s_new = {1'b0, {(SG_W-1){1'b1}}};
    end
    s_x     = ACC_W'(s_new);
    over_x  = $signed(ACC_W'(cfg.over_thr) << SMOOTH_FRAC_BITS);
    under_x = $signed(ACC_W'(cfg.under_thr) << SMOOTH_FRAC_BITS);
  end

  // Hold timers and the candidate rates, both in parallel with the EMA.
  always_comb begin
    now_ge = now >= st.last_change;
    since  = now - st.last_change;
    dec_ok = now_ge && (since >= TIME_W'(cfg.dec_hold));
    inc_ok = now_ge && (since >= TIME_W'(cfg.inc_hold));
    prod   = (RATE_W+16)'(st.rate) * (RATE_W+16)'(DEC_FACTOR);
    cut    = (prod[RATE_W+15:16] > cfg.min_rate) ? prod[RATE_W+15:16] : cfg.min_rate;
    up     = {1'b0, st.rate} + {1'b0, cfg.inc_step};
    if (up < {1'b0, cfg.max_rate}) begin
      up = up;
    end else begin
      up = {1'b0, cfg.max_rate};
    end
  end

  // Decision and state update.
  always_comb begin
    st_next              = st;
    st_next.have_prev    = 1'b1;
    st_next.prev_arrival = arrival;
    st_next.prev_sender  = sender;
    res.send             = 1'b0;
    res.status           = ST_FIRST;
    if (!st.have_prev) begin
      res.status = ST_FIRST;
    end else if (outlier) begin
      res.status = ST_OUTLIER;
    end else begin
      st_next.sgrad = s_new;
      res.status    = ST_KEEP;
      if (s_x > over_x) begin
        if (dec_ok) begin
          st_next.rate        = cut;
          st_next.last_change = now;
          st_next.sgrad       = '0;
          res.send            = 1'b1;
          res.status          = ST_DEC;
        end
      end else if ((s_x < under_x) && inc_ok) begin
        st_next.rate        = up[RATE_W-1:0];
        st_next.last_change = now;
        res.send            = 1'b1;
        res.status          = ST_INC;
      end
    end
    res.rate = st_next.rate;
  end

endmodule

// ===== rtl/delay_gradient_aimd_rate_estimator.sv =====
// Delay-gradient AIMD rate estimator. Each request carries one frame's sender
// timestamp, arrival time and current time, and produces exactly one result with
// the rate estimate, a report flag and a status code. A request is captured in an
// input register, evaluated combinationally against the estimator state, and the
// state and the result register are written together. The block takes one
// request per clock unless a held result stalls it, and each result is offered
// from the result register after its request has passed the input register.
// A result held by out_stall stalls the input only once the input register is also full.
// Configuration registers may be written at any time the block is idle.
module delay_gradient_aimd_rate_estimator
  import dgaimd_pkg::*;
#(
  parameter int SMOOTH_FRAC_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [SND_W-1:0]      sender_time_us,
  input  logic [TIME_W-1:0]     arrival_time_us,
  input  logic [TIME_W-1:0]     now_ms,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [RATE_W-1:0]     rate_bps,
  output logic                  send_rate_message,
  output logic [STATUS_W-1:0]   sample_status
);

  cfg_t              cfg;
  state_t            st;
  state_t            st_next;
  result_t           res;
  result_t           res_q;
  logic              s1_valid;
  logic [SND_W-1:0]  s1_sender;
  logic [TIME_W-1:0] s1_arrival;
  logic [TIME_W-1:0] s1_now;
  logic              advance;
  logic              in_take;

  dgaimd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dgaimd_update #(
    .SMOOTH_FRAC_BITS (SMOOTH_FRAC_BITS)
  ) u_update (
    .cfg     (cfg),
    .st      (st),
    .sender  (s1_sender),
    .arrival (s1_arrival),
    .now     (s1_now),
    .st_next (st_next),
    .res     (res)
  );

  // Handshake: the result register frees up when empty or taken.
  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_sender  <= sender_time_us;
      s1_arrival <= arrival_time_us;
      s1_now     <= now_ms;
    end
  end

  // Estimator state, updated as each request moves into the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= STATE_RESET;
    end else if (advance && s1_valid) begin
      st <= st_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      res_q <= res;
    end
  end

  assign rate_bps          = res_q.rate;
  assign send_rate_message = res_q.send;
  assign sample_status     = res_q.status;

endmodule

// ===== rtl/dgaimd_checker.sv =====
`include "delay_gradient_aimd_rate_estimator_defines.svh"

module dgaimd_checker
  import dgaimd_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [RATE_W-1:0]     rate_bps,
  input logic                  send_rate_message,
  input logic [STATUS_W-1:0]   sample_status
);

  // The report flag is set exactly for a rate change.
  `DGAIMD_ASSERT_NOW(a_send_matches_status, out_valid,
                     send_rate_message == ((sample_status == ST_DEC) ||
                                           (sample_status == ST_INC)))

  // The input side only stalls behind a held result.
  `DGAIMD_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall)

  // A held result does not change.
  `DGAIMD_ASSERT_NEXT(a_result_holds, out_valid && out_stall,
                      out_valid && $stable(rate_bps) && $stable(sample_status) &&
                      $stable(send_rate_message))

  // A new result after an idle output comes from a request that passed the input register.
  `DGAIMD_ASSERT_NOW(a_result_source, $rose(out_valid), $past(in_valid && !in_stall, 2))

endmodule

bind delay_gradient_aimd_rate_estimator dgaimd_checker u_dgaimd_checker (.*);
